/* hw/rtl/stwa_pkg.sv */
// ----------------------------------------------------------------------------
// Session table package
// Shared types and constants for the session table with aging.
// ----------------------------------------------------------------------------
`default_nettype none
package stwa_pkg;
   typedef enum logic [2:0] {
      MODE_LOAD  = 3'd0,
      MODE_FIND  = 3'd1,
      MODE_READ  = 3'd2,
      MODE_TICK  = 3'd3,
      MODE_FREE  = 3'd4,
      MODE_CLEAR = 3'd5,
      MODE_NOP6  = 3'd6,
      MODE_NOP7  = 3'd7
   } mode_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_ROW   = 2'd1;
   localparam logic [1:0] ST_BUSY      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic [15:0] RELOAD_RESET = 16'd255;
   localparam int          CSR_TIMEOUT_RELOAD = 0;

   typedef struct packed {
      mode_type    mode;
      logic [6:0]  row;
      logic [95:0] src_id;
      logic [95:0] dst_id;
      logic [31:0] process_number;
      logic [7:0]  function_code;
      logic [15:0] data_length;
      logic [31:0] data_handle;
      logic        which_id;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  row_out;
      logic [95:0] id;
   } rsp_type;

   typedef enum logic [2:0] {
      BE_IDLE  = 3'd0,
      BE_SCAN  = 3'd1,
      BE_WAIT  = 3'd2,
      BE_CHECK = 3'd3,
      BE_DONE  = 3'd4
   } be_state_type;
endpackage
`default_nettype wire

/* hw/rtl/stwa_if.sv */
// ----------------------------------------------------------------------------
// Session table channel interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none
interface stwa_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [6:0]  row;
   logic [63:0] src_id_low;
   logic [31:0] src_id_high;
   logic [63:0] dst_id_low;
   logic [31:0] dst_id_high;
   logic [31:0] process_number;
   logic [7:0]  function_code;
   logic [15:0] data_length;
   logic [31:0] data_handle;
   logic        which_id;
   modport source(output valid, mode, row, src_id_low, src_id_high, dst_id_low,
      dst_id_high, process_number, function_code, data_length, data_handle,
      which_id, input ready);
   modport sink(input valid, mode, row, src_id_low, src_id_high, dst_id_low,
      dst_id_high, process_number, function_code, data_length, data_handle,
      which_id, output ready);
endinterface

interface stwa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  row_out;
   logic [63:0] id_low_out;
   logic [31:0] id_high_out;
   modport source(output valid, status, row_out, id_low_out, id_high_out,
      input ready);
   modport sink(input valid, status, row_out, id_low_out, id_high_out,
      output ready);
endinterface
`default_nettype wire

/* hw/rtl/stwa_front.sv */
// ----------------------------------------------------------------------------
// Session table front end
// Accept request transactions and queue them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module stwa_front
   import stwa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   stwa_req_if.sink     req,
   output cmd_type      cmd,
   output logic         cmd_valid,
   input  wire logic    cmd_take
);
   // two-entry queue
   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      q_in.mode           = mode_type'(req.mode);
      q_in.row            = req.row;
      q_in.src_id         = {req.src_id_high, req.src_id_low};
      q_in.dst_id         = {req.dst_id_high, req.dst_id_low};
      q_in.process_number = req.process_number;
      q_in.function_code  = req.function_code;
      q_in.data_length    = req.data_length;
      q_in.data_handle    = req.data_handle;
      q_in.which_id       = req.which_id;
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/stwa_back.sv */
// ----------------------------------------------------------------------------
// Session table back end
// Execute commands against the row memory and the aging sweep.
// ----------------------------------------------------------------------------
`default_nettype none
module stwa_back
   import stwa_pkg::*;
#(
   parameter int ROWS        = 64,
   parameter int SWEEP_CHUNK = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] reload,
   input  wire cmd_type     cmd,
   input  wire logic        cmd_valid,
   output logic             cmd_take,
   output rsp_type          rsp,
   output logic             rsp_valid,
   input  wire logic        rsp_ready
);
   localparam int AW     = $clog2(ROWS);
   localparam int CHUNKS = (ROWS + SWEEP_CHUNK - 1) / SWEEP_CHUNK;
   localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int DW     = 96 + 96 + 32 + 8 + 16 + 32;

   // data memory (IDs and payload), timers and valid bits
   logic [DW-1:0] mem [ROWS];
   logic [15:0]   tmr [ROWS];
   logic [ROWS-1:0] vld_ff;
   logic [DW-1:0] rd_ff;
   logic [15:0]   trd_ff;
   logic [AW-1:0] raddr;
   logic          wr_en;
   logic [AW-1:0] waddr;
   logic [DW-1:0] wdata;
   logic          tw_en;
   logic [15:0]   tw_data;

   be_state_type state_ff, state_in;
   cmd_type      c_ff;
   logic [AW:0]  idx_ff, idx_in, end_ff;
   logic [CW-1:0] chunk_ff;
   rsp_type      out_ff, res;
   logic         ov_ff, res_en, lat_cmd, found, ir;
   logic [AW-1:0] ia;
   logic [95:0]  msrc, mdst;
   logic         hit;

   assign ir   = c_ff.row < 7'(ROWS);
   assign ia   = idx_ff[AW-1:0];
   assign msrc = rd_ff[DW-1 -: 96];
   assign mdst = rd_ff[DW-97 -: 96];
   assign hit  = vld_ff[ia] && (c_ff.function_code[6] || mdst == c_ff.dst_id)
                 && (c_ff.function_code[7] || msrc == c_ff.src_id);

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end
   always_ff @(posedge clock) begin
      if (tw_en) tmr[waddr] <= tw_data;
      trd_ff <= tmr[raddr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE: if (lat_cmd) state_in = BE_SCAN;
         BE_SCAN: begin
            case (c_ff.mode)
               MODE_FIND, MODE_TICK, MODE_READ: state_in = BE_WAIT;
               MODE_FREE: if (found || idx_ff == end_ff) state_in = BE_DONE;
               default: state_in = BE_DONE;
            endcase
         end
         BE_WAIT:  state_in = BE_CHECK;
         BE_CHECK: begin
            if (c_ff.mode == MODE_READ) state_in = BE_DONE;
            else if (c_ff.mode == MODE_FIND && hit) state_in = BE_DONE;
            else if (idx_ff + 1'b1 == end_ff) state_in = BE_DONE;
            else state_in = BE_WAIT;
         end
         BE_DONE: if (!ov_ff || rsp_ready) state_in = BE_IDLE;
         default: state_in = BE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      // hold the next command until the waiting response leaves
      cmd_take = (state_ff == BE_IDLE) && (!ov_ff || rsp_ready);
      lat_cmd  = cmd_take && cmd_valid;
      wr_en    = 1'b0;
      tw_en    = 1'b0;
      waddr    = c_ff.row[AW-1:0];
      wdata    = '0;
      tw_data  = reload;
      raddr    = ia;
      idx_in   = idx_ff;
      found    = !vld_ff[ia];
      res      = out_ff;
      res_en   = 1'b0;
      case (state_ff)
         BE_SCAN: begin
            res    = '0;
            res_en = 1'b1;
            case (c_ff.mode)
               MODE_LOAD: begin
                  if (!ir) res.status = ST_BAD_ROW;
                  else begin
                     res.row_out = c_ff.row[5:0];
                     if (vld_ff[c_ff.row[AW-1:0]]) res.status = ST_BUSY;
                     else begin
                        wr_en = 1'b1;
                        tw_en = 1'b1;
                        wdata = {c_ff.src_id, c_ff.dst_id, c_ff.process_number,
                                 c_ff.function_code, c_ff.data_length,
                                 c_ff.data_handle};
                     end
                  end
               end
               MODE_CLEAR: begin
                  if (!ir) res.status = ST_BAD_ROW;
                  else begin
                     res.row_out = c_ff.row[5:0];
                     wr_en = 1'b1;
                     tw_en = 1'b1;
                  end
               end
               MODE_READ: begin
                  raddr  = c_ff.row[AW-1:0];
                  idx_in = {1'b0, c_ff.row[AW-1:0]};
                  if (!ir) res.status = ST_BAD_ROW;
                  else res.row_out = c_ff.row[5:0];
               end
               MODE_FIND: res.status = ST_NOT_FOUND;
               MODE_FREE: begin
                  if (idx_ff == end_ff) res.status = ST_BUSY;
                  else if (found) res.row_out = 6'(idx_ff);
                  else res_en = 1'b0;
                  idx_in = idx_ff + 1'b1;
               end
               default: ;
            endcase
         end
         BE_CHECK: begin
            case (c_ff.mode)
               MODE_READ: begin
                  // an invalid row always reads as zero IDs; never-written
                  // entries are masked here instead of cleared at reset
                  res_en = ir;
                  res.id = vld_ff[c_ff.row[AW-1:0]] ?
                           (c_ff.which_id ? mdst : msrc) : '0;
               end
               MODE_FIND: begin
                  res_en = hit;
                  res.status = ST_OK;
                  res.row_out = 6'(idx_ff);
               end
               MODE_TICK: begin
                  waddr = ia;
                  if (vld_ff[ia]) begin
                     tw_en = 1'b1;
                     if (trd_ff != 16'd0) tw_data = trd_ff - 16'd1;
                     else wr_en = 1'b1;
                  end
               end
               default: ;
            endcase
            idx_in = idx_ff + 1'b1;
            raddr  = AW'(idx_ff + 1'b1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (res_en) out_ff <= res;
      if (lat_cmd) c_ff <= cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         vld_ff   <= '0;
         chunk_ff <= '0;
         ov_ff    <= 1'b0;
         idx_ff   <= '0;
         end_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (lat_cmd) begin
            if (cmd.mode == MODE_TICK) begin
               idx_ff <= (AW+1)'(chunk_ff * SWEEP_CHUNK);
               if ((int'(chunk_ff) + 1) * SWEEP_CHUNK >= ROWS)
                  end_ff <= (AW+1)'(ROWS);
               else end_ff <= (AW+1)'((int'(chunk_ff) + 1) * SWEEP_CHUNK);
               chunk_ff <= (int'(chunk_ff) + 1 >= CHUNKS) ? '0 : chunk_ff + 1'b1;
            end else begin
               idx_ff <= '0;
               end_ff <= (AW+1)'(ROWS);
            end
         end else begin
            idx_ff <= idx_in;
         end
         if (wr_en) vld_ff[waddr] <= (state_ff == BE_SCAN) &&
                                     (c_ff.mode == MODE_LOAD);
         if (state_ff == BE_DONE && state_in == BE_IDLE) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
      end
   end

   assign rsp       = out_ff;
   assign rsp_valid = ov_ff;
endmodule
`default_nettype wire

/* hw/rtl/session_table_with_aging.sv */
// ----------------------------------------------------------------------------
// Session table with aging
// Each transaction passes the back end states IDLE, SCAN and DONE; free walks
// its rows in SCAN, and find, read and tick step through WAIT and CHECK per row.
// One transaction is executed at a time, set by the row walk over the row
// memory; the front queue holds two waiting transactions,
// and a response not yet taken holds the next one in the queue.
// Reset (synchronous, active high) clears all valid bits, the sweep pointer
// and the reload register to 255; an invalid row reads as zero, so the row
// memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module session_table_with_aging
   import stwa_pkg::*;
#(
   parameter int ROWS        = 64,
   parameter int SWEEP_CHUNK = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   stwa_req_if.sink         req,
   stwa_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   cmd_type     cmd;
   rsp_type     res;
   logic        cmd_valid, cmd_take;
   logic [15:0] reload_ff;

   assign csr_pready = 1'b1;
   // register index 0 sits at byte address 0
   assign csr_prdata = (csr_paddr == 2'(CSR_TIMEOUT_RELOAD * 4)) ?
                       {16'd0, reload_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) reload_ff <= RELOAD_RESET;
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr == 2'(CSR_TIMEOUT_RELOAD * 4))
         reload_ff <= csr_pwdata[15:0];
   end

   stwa_front u_front (
      .clock, .reset, .req, .cmd, .cmd_valid, .cmd_take
   );

   stwa_back #(.ROWS(ROWS), .SWEEP_CHUNK(SWEEP_CHUNK)) u_back (
      .clock, .reset, .reload(reload_ff), .cmd, .cmd_valid, .cmd_take,
      .rsp(res), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
   );

   // drive the response payload
   assign rsp.status      = res.status;
   assign rsp.row_out     = res.row_out;
   assign rsp.id_low_out  = res.id[63:0];
   assign rsp.id_high_out = res.id[95:64];
endmodule
`default_nettype wire

/* dv/stwa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session table checker
// Watches the request and response channels, keeps a shadow of the table and
// compares every response with the predicted one, oldest first.
// ----------------------------------------------------------------------------
module stwa_checker
   import stwa_pkg::*;
#(
   parameter int ROWS        = 64,
   parameter int SWEEP_CHUNK = 32
) (
   input  logic        clock,
   input  logic        reset,
   stwa_req_if         req,
   stwa_rsp_if         rsp,
   input  logic        reload_we,
   input  logic [15:0] reload_value,
   output int          fail_count,
   output int          pending_count,
   output int          rsp_count
);
   localparam int CHUNKS = (ROWS + SWEEP_CHUNK - 1) / SWEEP_CHUNK;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  row_out;
      logic [63:0] id_low;
      logic [31:0] id_high;
   } answer_type;

   logic        shadow_valid [ROWS];
   logic [95:0] shadow_src   [ROWS];
   logic [95:0] shadow_dst   [ROWS];
   logic [15:0] shadow_timer [ROWS];
   logic [15:0] reload;
   int          chunk;
   answer_type  answers [$];

   function automatic void empty_shadow(int r);
      shadow_valid[r] = 1'b0;
      shadow_src[r]   = '0;
      shadow_dst[r]   = '0;
      shadow_timer[r] = reload;
   endfunction

   function automatic answer_type table_step();
      answer_type  a;
      logic [95:0] s_id;
      logic [95:0] d_id;
      int          r;
      int          base;
      logic        in_range;
      a        = '0;
      s_id     = {req.src_id_high, req.src_id_low};
      d_id     = {req.dst_id_high, req.dst_id_low};
      r        = int'(req.row);
      in_range = r < ROWS;
      case (mode_type'(req.mode))
         MODE_LOAD: begin
            if (!in_range) a.status = ST_BAD_ROW;
            else if (shadow_valid[r]) begin
               a.status  = ST_BUSY;
               a.row_out = 6'(r);
            end else begin
               shadow_valid[r] = 1'b1;
               shadow_src[r]   = s_id;
               shadow_dst[r]   = d_id;
               shadow_timer[r] = reload;
               a.row_out       = 6'(r);
            end
         end
         MODE_FIND: begin
            a.status = ST_NOT_FOUND;
            for (int i = 0; i < ROWS; i++) begin
               if (shadow_valid[i] && (req.function_code[6] || shadow_dst[i] == d_id)
                   && (req.function_code[7] || shadow_src[i] == s_id)) begin
                  a.status  = ST_OK;
                  a.row_out = 6'(i);
                  break;
               end
            end
         end
         MODE_READ: begin
            if (!in_range) a.status = ST_BAD_ROW;
            else begin
               a.row_out = 6'(r);
               {a.id_high, a.id_low} = req.which_id ? shadow_dst[r] : shadow_src[r];
            end
         end
         MODE_TICK: begin
            base = chunk * SWEEP_CHUNK;
            for (int i = base; i < base + SWEEP_CHUNK && i < ROWS; i++) begin
               if (shadow_valid[i]) begin
                  if (shadow_timer[i] != 0) shadow_timer[i] = shadow_timer[i] - 1'b1;
                  else empty_shadow(i);
               end
            end
            chunk = (chunk + 1 >= CHUNKS) ? 0 : chunk + 1;
         end
         MODE_FREE: begin
            a.status = ST_BUSY;
            for (int i = 0; i < ROWS; i++) begin
               if (!shadow_valid[i]) begin
                  a.status  = ST_OK;
                  a.row_out = 6'(i);
                  break;
               end
            end
         end
         MODE_CLEAR: begin
            if (!in_range) a.status = ST_BAD_ROW;
            else begin
               empty_shadow(r);
               a.row_out = 6'(r);
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         reload = RELOAD_RESET;
         chunk  = 0;
         for (int i = 0; i < ROWS; i++) empty_shadow(i);
         answers.delete();
         fail_count = 0;
         rsp_count  = 0;
      end else begin
         if (reload_we) reload = reload_value;
         if (rsp.valid && rsp.ready) begin
            rsp_count++;
            if (answers.size() == 0) begin
               $display("%0t: response with nothing expected: status %0d row %0d",
                  $time, rsp.status, rsp.row_out);
               fail_count++;
            end else begin
               want = answers.pop_front();
               if (want != {rsp.status, rsp.row_out, rsp.id_low_out, rsp.id_high_out}) begin
                  $display("%0t: mismatch expected st=%0d row=%0d id=%h_%h",
                     $time, want.status, want.row_out, want.id_high, want.id_low);
                  $display("%0t:          actual   st=%0d row=%0d id=%h_%h",
                     $time, rsp.status, rsp.row_out, rsp.id_high_out, rsp.id_low_out);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) answers.push_back(table_step());
      end
      pending_count = answers.size();
   end
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session table testbench
// Drives directed and random load/find/read/tick/free/clear traffic with
// bursty requests and a stalling receiver, rewrites the timeout reload
// between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import stwa_pkg::*;

   localparam int ROWS = 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_count;
   int          rsp_count;
   int          sent_count = 0;
   logic        hold_off = 1'b0;   // long receiver stall on request
   logic [95:0] known_ids [8];      // small ID pool so finds really hit

   stwa_req_if req ();
   stwa_rsp_if rsp ();

   session_table_with_aging DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready));

   // The write lands at the access edge; tell the checker on the same edge.
   stwa_checker CHK (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .reload_we(csr_psel && csr_penable && csr_pwrite && csr_pready
                 && csr_paddr == 2'(CSR_TIMEOUT_RELOAD * 4)),
      .reload_value(csr_pwdata[15:0]),
      .fail_count(fail_count), .pending_count(pending_count),
      .rsp_count(rsp_count));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop well above the slowest legal run (about 1300 items).
   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Receiver: random stall pattern, idle-free stretches, and the long hold-off.
   initial begin
      int pattern;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         pattern = int'(($time / 20000) % 3);
         if (hold_off) rsp.ready <= 1'b0;
         else if (pattern == 0) rsp.ready <= 1'b1;
         else rsp.ready <= ($urandom_range(0, 3) != 0) || pattern == 2 && $urandom_range(0, 1);
      end
   end

   // Write the reload register through a setup phase and then an access phase.
   task automatic write_reload(input logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 2'(CSR_TIMEOUT_RELOAD * 4);
      csr_pwdata  <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offer one transaction and hold it until it is taken.
   task automatic send_cmd(input mode_type mode, input logic [6:0] row,
                           input logic [95:0] s_id, input logic [95:0] d_id,
                           input logic [7:0] func, input logic which);
      req.valid          <= 1'b1;
      req.mode           <= mode;
      req.row            <= row;
      req.src_id_low     <= s_id[63:0];
      req.src_id_high    <= s_id[95:64];
      req.dst_id_low     <= d_id[63:0];
      req.dst_id_high    <= d_id[95:64];
      req.process_number <= $urandom;
      req.function_code  <= func;
      req.data_length    <= 16'($urandom);
      req.data_handle    <= $urandom;
      req.which_id       <= which;
      do @(posedge clock); while (!req.ready);
      sent_count++;
   endtask

   task automatic idle_req(input int cycles);
      req.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Wait for every answer, then idle a while before the next phase.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2 * ROWS + 20) @(posedge clock);
   endtask

   function automatic logic [95:0] rand_id();
      return {$urandom, $urandom, $urandom};
   endfunction

   // Mostly pooled IDs so that loads collide and finds match.
   function automatic logic [95:0] pick_id();
      return ($urandom_range(0, 3) != 0) ? known_ids[$urandom_range(0, 7)] : rand_id();
   endfunction

   // Random item: modes weighted toward table traffic, rows mostly in range.
   task automatic send_random();
      int          pick;
      mode_type    mode;
      logic [6:0]  row;
      pick = $urandom_range(0, 99);
      if (pick < 28) mode = MODE_LOAD;
      else if (pick < 48) mode = MODE_FIND;
      else if (pick < 60) mode = MODE_READ;
      else if (pick < 74) mode = MODE_TICK;
      else if (pick < 82) mode = MODE_FREE;
      else if (pick < 96) mode = MODE_CLEAR;
      else mode = mode_type'($urandom_range(6, 7));
      row = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(64, 127))
                                        : 7'($urandom_range(0, ROWS - 1));
      send_cmd(mode, row, pick_id(), pick_id(), 8'($urandom), 1'($urandom));
   endtask

   initial begin
      req.valid          <= 1'b0;
      req.mode           <= MODE_NOP6;
      req.row            <= '0;
      req.src_id_low     <= '0;
      req.src_id_high    <= '0;
      req.dst_id_low     <= '0;
      req.dst_id_high    <= '0;
      req.process_number <= '0;
      req.function_code  <= '0;
      req.data_length    <= '0;
      req.data_handle    <= '0;
      req.which_id       <= 1'b0;
      for (int i = 0; i < 8; i++) known_ids[i] = rand_id();
      known_ids[0] = '1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every mode, busy/bad row, skip bits, aging to zero.
      send_cmd(MODE_READ, 7'd63, '0, '0, 8'h00, 1'b0);      // never-loaded row reads zero
      send_cmd(MODE_FIND, 7'd0, '0, '0, 8'hC0, 1'b0);       // empty table: not found
      send_cmd(MODE_LOAD, 7'd0, '1, '0, 8'hFF, 1'b0);
      send_cmd(MODE_LOAD, 7'd63, '0, '1, 8'h00, 1'b1);
      send_cmd(MODE_LOAD, 7'd0, '0, '0, 8'h00, 1'b0);       // busy
      send_cmd(MODE_LOAD, 7'd127, '1, '1, 8'hFF, 1'b1);     // bad row
      send_cmd(MODE_LOAD, 7'd64, '0, '0, 8'h00, 1'b0);      // bad row
      send_cmd(MODE_FIND, 7'd0, '0, '1, 8'h00, 1'b0);       // full compare
      send_cmd(MODE_FIND, 7'd0, '1, '1, 8'h40, 1'b0);       // skip destination
      send_cmd(MODE_FIND, 7'd0, '0, '1, 8'h80, 1'b0);       // skip source
      send_cmd(MODE_FIND, 7'd0, '0, '0, 8'hC0, 1'b0);       // lowest valid row
      send_cmd(MODE_READ, 7'd0, '0, '0, 8'h00, 1'b0);
      send_cmd(MODE_READ, 7'd63, '0, '0, 8'h00, 1'b1);
      send_cmd(MODE_READ, 7'd100, '0, '0, 8'h00, 1'b1);
      send_cmd(MODE_FREE, 7'd0, '0, '0, 8'h00, 1'b0);
      send_cmd(MODE_CLEAR, 7'd0, '0, '0, 8'h00, 1'b0);
      send_cmd(MODE_CLEAR, 7'd99, '0, '0, 8'h00, 1'b0);
      send_cmd(MODE_NOP6, 7'd5, '1, '1, 8'hFF, 1'b1);
      send_cmd(MODE_NOP7, 7'd5, '1, '1, 8'hFF, 1'b1);
      drain();

      // Reload of zero: a load lives one tick of its chunk, then goes.
      write_reload(16'd0);
      send_cmd(MODE_LOAD, 7'd1, known_ids[1], known_ids[2], 8'h00, 1'b0);
      repeat (4) send_cmd(MODE_TICK, 7'd0, '0, '0, 8'h00, 1'b0);
      send_cmd(MODE_READ, 7'd1, '0, '0, 8'h00, 1'b0);
      send_cmd(MODE_FIND, 7'd0, known_ids[1], known_ids[2], 8'h00, 1'b0);
      drain();

      // Random phases, each under its own reload, extremes included.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_reload(16'd2);
            1: write_reload(16'hFFFF);
            2: write_reload(16'($urandom_range(0, 6)));
            3: write_reload(16'd1);
            default: write_reload(16'($urandom));
         endcase
         // Phase 1: fill the table so that free search reports none.
         if (phase == 1)
            for (int r = 0; r < ROWS; r++)
               send_cmd(MODE_LOAD, 7'(r), rand_id(), rand_id(), 8'($urandom), 1'b0);
         for (int n = 0; n < 240; n++) begin
            // Hold the receiver off once while requests keep coming.
            if (phase == 2 && n == 20) begin
               fork
                  begin
                     hold_off = 1'b1;
                     repeat (3000) @(posedge clock);
                     hold_off = 1'b0;
                  end
               join_none
            end
            // Wait out every answer once mid-phase.
            if (phase == 3 && n == 100) begin
               req.valid <= 1'b0;
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
            send_random();
            if ($urandom_range(0, 5) == 0) idle_req($urandom_range(1, 20));
         end
         drain();
      end

      $display("Covered %0d transactions, %0d responses checked, over reloads 0..65535",
         sent_count, rsp_count);
      $display("with bursty senders, receiver stalls, a full table and aging to expiry.");
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
